FILE: design/ifof_pkg.sv
// Shared types and constants for the IPv4 fragment option filter.
package ifof_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 6;

  localparam logic [BYTE_W-1:0] OPT_EOL    = 8'h00;
  localparam logic [BYTE_W-1:0] OPT_NOP    = 8'h01;
  localparam int                COPIED_POS = 7;
  localparam logic [1:0]        PAD_MASK   = 2'h3;

  // Command from the parser to the result sequencer.
  typedef struct packed {
    logic              emit;   // one kept byte goes out first
    logic [BYTE_W-1:0] data;   // the kept byte
    logic              last;   // closes the run
    logic [1:0]        npad;   // EOL pad bytes after the kept byte
    logic [CNT_W-1:0]  plen;   // padded length, reported at end of run
  } cmd_t;

  // Queue status toward its producer and consumer.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

FILE: design/ifof_if.sv
// Request channel interfaces: option bytes in, filtered results out.
interface ifof_in_if;
  logic                        valid;
  logic                        ready;
  logic [ifof_pkg::BYTE_W-1:0] opt_byte;
  logic [ifof_pkg::CNT_W-1:0]  area_len;
  logic                        last;

  modport source(output valid, opt_byte, area_len, last, input ready);
  modport sink(input valid, opt_byte, area_len, last, output ready);
endinterface

interface ifof_out_if;
  logic                        valid;
  logic                        ready;
  logic [ifof_pkg::BYTE_W-1:0] out_byte;
  logic                        has_byte;
  logic                        end_of_run;
  logic [ifof_pkg::CNT_W-1:0]  padded_len;

  modport source(output valid, out_byte, has_byte, end_of_run, padded_len, input ready);
  modport sink(input valid, out_byte, has_byte, end_of_run, padded_len, output ready);
endinterface

FILE: design/ipv4_fragment_option_filter_core.sv
// Top level of the IPv4 fragment option filter.
// A kept byte reaches res_out via the command queue and the output register.
// Throughput: one option byte per cycle while the command queue has room; the closing byte
// of an area produces up to four results, one per cycle unless res_out stalls, limited by
// the single output register. A two-entry command queue lets the parser run ahead while
// results stall. Reset (rst, synchronous) clears parser state, queue and output valid.
module ipv4_fragment_option_filter_core #(
  parameter int MAX_OPTION_BYTES = 40
) (
  input  logic       clk,
  input  logic       rst,
  ifof_in_if.sink    in_ch,
  ifof_out_if.source res_out
);
  import ifof_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_status;

  ifof_front #(
    .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ifof_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ifof_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .res_out  (res_out)
  );

endmodule

FILE: design/ifof_front.sv
// Option parser: walks the option area one byte per request and issues commands.
module ifof_front #(
  parameter int MAX_OPTION_BYTES = 40
) (
  input  logic               clk,
  input  logic               rst,
  ifof_in_if.sink            in_ch,
  input  ifof_pkg::q_status_t q_status,
  output logic               push,
  output ifof_pkg::cmd_t     push_cmd
);
  import ifof_pkg::*;

  localparam logic [CNT_W-1:0] MAX_LIM = CNT_W'(MAX_OPTION_BYTES);

  logic [CNT_W-1:0] bytes_seen, bytes_seen_next;
  logic [CNT_W-1:0] option_left, option_left_next;
  logic             want_length, want_length_next;
  logic             keep_current, keep_current_next;
  logic             stopped, stopped_next;
  logic [CNT_W-1:0] kept_count;

  logic              accept;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  rem;
  logic              active;
  logic              emit;
  logic [BYTE_W-1:0] len;
  logic [BYTE_W-1:0] data_len;
  logic [CNT_W-1:0]  kept_next;
  logic [1:0]        npad;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Parse one byte
  always_comb begin
    lim    = (in_ch.area_len < MAX_LIM) ? in_ch.area_len : MAX_LIM;
    active = !stopped && (bytes_seen < lim);
    rem    = lim - bytes_seen - CNT_W'(1);
    len    = (in_ch.opt_byte < BYTE_W'(2)) ? BYTE_W'(2) : in_ch.opt_byte;
    data_len = len - BYTE_W'(2);

    bytes_seen_next   = bytes_seen;
    option_left_next  = option_left;
    want_length_next  = want_length;
    keep_current_next = keep_current;
    stopped_next      = stopped;
    emit              = 1'b0;

    if (active) begin
      if (want_length) begin
        option_left_next = (data_len < {2'b00, rem}) ? data_len[CNT_W-1:0] : rem;
        want_length_next = 1'b0;
        emit             = keep_current;
      end else if (option_left != '0) begin
        option_left_next = option_left - CNT_W'(1);
        emit             = keep_current;
      end else if (in_ch.opt_byte == OPT_EOL) begin
        stopped_next = 1'b1;
      end else if (in_ch.opt_byte == OPT_NOP) begin
        emit = 1'b1;
      end else begin
        keep_current_next = in_ch.opt_byte[COPIED_POS];
        want_length_next  = 1'b1;
        emit              = in_ch.opt_byte[COPIED_POS];
      end
      bytes_seen_next = bytes_seen + CNT_W'(1);
    end

    // Pad the kept count up to a multiple of four
    kept_next = kept_count + CNT_W'(emit);
    npad      = (2'd0 - kept_next[1:0]) & PAD_MASK;
  end

  assign push          = accept && (emit || in_ch.last);
  assign push_cmd.emit = emit;
  assign push_cmd.data = in_ch.opt_byte;
  assign push_cmd.last = in_ch.last;
  assign push_cmd.npad = in_ch.last ? npad : 2'd0;
  assign push_cmd.plen = in_ch.last ? (kept_next + CNT_W'(npad)) : '0;

  // Parser state; cleared at end of each area
  always_ff @(posedge clk) begin
    if (rst || (accept && in_ch.last)) begin
      bytes_seen   <= '0;
      option_left  <= '0;
      want_length  <= 1'b0;
      keep_current <= 1'b0;
      stopped      <= 1'b0;
      kept_count   <= '0;
    end else if (accept) begin
      bytes_seen   <= bytes_seen_next;
      option_left  <= option_left_next;
      want_length  <= want_length_next;
      keep_current <= keep_current_next;
      stopped      <= stopped_next;
      kept_count   <= kept_next;
    end
  end

endmodule

FILE: design/ifof_queue.sv
// Two-entry command queue between the parser and the result sequencer.
module ifof_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ifof_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output ifof_pkg::cmd_t      head,
  output ifof_pkg::q_status_t status
);
  import ifof_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head             = entry[rd_ptr];
  assign status.full      = (count == 2'd2);
  assign status.not_empty = (count != 2'd0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/ifof_back.sv
// Result sequencer: expands each command into one to four results.
module ifof_back (
  input  logic                clk,
  input  logic                rst,
  input  ifof_pkg::cmd_t      head,
  input  ifof_pkg::q_status_t q_status,
  output logic                pop,
  ifof_out_if.source          res_out
);
  import ifof_pkg::*;

  logic [1:0]        step;
  logic [2:0]        n_res;
  logic [1:0]        final_step;
  logic              bare;
  logic              load;
  logic              is_final;
  logic [BYTE_W-1:0] nxt_byte;
  logic              nxt_has;

  // Pick the result for the current step of the head command
  always_comb begin
    n_res      = 3'(head.emit) + 3'(head.npad);
    bare       = (n_res == 3'd0);
    final_step = bare ? 2'd0 : 2'(n_res - 3'd1);
    is_final   = (step == final_step);
    if (head.emit && step == 2'd0) begin
      nxt_byte = head.data;
      nxt_has  = 1'b1;
    end else begin
      nxt_byte = OPT_EOL;
      nxt_has  = !bare;
    end
  end

  assign load = q_status.not_empty && (!res_out.valid || res_out.ready);
  assign pop  = load && is_final;

  // Step counter within a command
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
    end else if (load) begin
      step <= is_final ? 2'd0 : step + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (!res_out.valid || res_out.ready) begin
      res_out.valid <= q_status.not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out.out_byte   <= nxt_byte;
      res_out.has_byte   <= nxt_has;
      res_out.end_of_run <= head.last && is_final;
      res_out.padded_len <= (head.last && is_final) ? head.plen : '0;
    end
  end

endmodule

FILE: design/ifof_checker.sv
// Port-level checks on the result channel of the option filter.
module ifof_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       end_of_run,
  input logic [5:0] padded_len
);

  // Length is only reported on the closing result
  a_len_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_run |-> padded_len == 6'd0)
    else $error("padded_len nonzero before end of run");

  // A bare marker only closes a run and carries no byte
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> end_of_run && out_byte == 8'd0)
    else $error("bare marker malformed");

  // Padded length is a multiple of four
  a_pad_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_run |-> padded_len[1:0] == 2'd0)
    else $error("padded_len not aligned to four");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(end_of_run))
    else $error("result changed while stalled");

endmodule

bind ipv4_fragment_option_filter_core ifof_checker u_ifof_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (res_out.valid),
  .out_ready  (res_out.ready),
  .out_byte   (res_out.out_byte),
  .has_byte   (res_out.has_byte),
  .end_of_run (res_out.end_of_run),
  .padded_len (res_out.padded_len)
);

FILE: dv/ifof_kept_byte_checker.sv
// Checker for the fragment option filter: predicts the kept bytes and compares results.
module ifof_kept_byte_checker #(
  parameter int MAX_OPTION_BYTES = 40
) (
  input  logic clk,
  input  logic rst,
  ifof_in_if   in_ch,
  ifof_out_if  res_out,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ifof_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              end_of_run;
    logic [CNT_W-1:0]  padded_len;
  } result_t;

  result_t due_results[$];
  int      errors;

  // Parser state of one option area
  logic [CNT_W-1:0] bytes_seen;
  logic [CNT_W-1:0] option_left;
  logic [CNT_W-1:0] kept_count;
  logic             want_length;
  logic             keep_current;
  logic             stopped;

  task automatic clear_parser();
    bytes_seen   = '0;
    option_left  = '0;
    kept_count   = '0;
    want_length  = 1'b0;
    keep_current = 1'b0;
    stopped      = 1'b0;
  endtask

  // Work out the results one accepted option byte causes
  task automatic filter_option_byte(input logic [BYTE_W-1:0] opt_byte,
                                    input logic [CNT_W-1:0] area_len,
                                    input logic last);
    result_t step_res[4];
    int      n;
    int      lim;
    int      rem;
    int      len;
    int      plen;
    logic    emit;
    n    = 0;
    emit = 1'b0;
    lim  = (int'(area_len) < MAX_OPTION_BYTES) ? int'(area_len) : MAX_OPTION_BYTES;

    if (!stopped && int'(bytes_seen) < lim) begin
      rem = lim - int'(bytes_seen) - 1;
      if (want_length) begin
        // lengths below 2 count as 2; long ones stop at the area's end
        len          = (int'(opt_byte) < 2) ? 2 : int'(opt_byte);
        option_left  = CNT_W'(((len - 2) < rem) ? (len - 2) : rem);
        want_length  = 1'b0;
        emit         = keep_current;
      end else if (option_left != 0) begin
        option_left = option_left - 1'b1;
        emit        = keep_current;
      end else if (opt_byte == OPT_EOL) begin
        stopped = 1'b1;
      end else if (opt_byte == OPT_NOP) begin
        emit = 1'b1;
      end else begin
        keep_current = opt_byte[COPIED_POS];
        want_length  = 1'b1;
        emit         = keep_current;
      end
      bytes_seen = bytes_seen + 1'b1;
    end

    if (emit) begin
      kept_count  = kept_count + 1'b1;
      step_res[n] = '{out_byte: opt_byte, has_byte: 1'b1, end_of_run: 1'b0, padded_len: '0};
      n++;
    end

    // Close the run: EOL pads to a multiple of four, or a bare end marker
    if (last) begin
      plen = int'(kept_count);
      while ((plen & int'(PAD_MASK)) != 0) begin
        step_res[n] = '{out_byte: OPT_EOL, has_byte: 1'b1, end_of_run: 1'b0, padded_len: '0};
        n++;
        plen++;
      end
      if (n == 0) begin
        step_res[0] = '{out_byte: '0, has_byte: 1'b0, end_of_run: 1'b1,
                        padded_len: CNT_W'(plen)};
        n = 1;
      end else begin
        step_res[n-1].end_of_run = 1'b1;
        step_res[n-1].padded_len = CNT_W'(plen);
      end
      clear_parser();
    end

    for (int k = 0; k < n; k++) due_results.push_back(step_res[k]);
  endtask

  // Compare one accepted result with the oldest one due
  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      errors++;
      $error("unexpected result: out_byte %0h has_byte %0b end_of_run %0b padded_len %0d",
             res_out.out_byte, res_out.has_byte, res_out.end_of_run, res_out.padded_len);
      return;
    end
    want = due_results.pop_front();
    if (res_out.out_byte !== want.out_byte) begin
      errors++;
      $error("out_byte: expected %0h, got %0h", want.out_byte, res_out.out_byte);
    end
    if (res_out.has_byte !== want.has_byte) begin
      errors++;
      $error("has_byte: expected %0b, got %0b", want.has_byte, res_out.has_byte);
    end
    if (res_out.end_of_run !== want.end_of_run) begin
      errors++;
      $error("end_of_run: expected %0b, got %0b", want.end_of_run, res_out.end_of_run);
    end
    if (res_out.padded_len !== want.padded_len) begin
      errors++;
      $error("padded_len: expected %0d, got %0d", want.padded_len, res_out.padded_len);
    end
  endtask

  initial clear_parser();

  // Requests are predicted before results are checked at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      due_results.delete();
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        filter_option_byte(in_ch.opt_byte, in_ch.area_len, in_ch.last);
      if (res_out.valid === 1'b1 && res_out.ready === 1'b1)
        check_result();
    end
    fail_count <= errors;
    pending    <= due_results.size();
  end

endmodule

FILE: dv/tb_ipv4_fragment_option_filter_core.sv
// Testbench top for the IPv4 fragment option filter: stimulus, stalls and verdict.
module tb_ipv4_fragment_option_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ifof_pkg::*;

  localparam int MAX_BYTES   = 40;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_REQS = 250;

  // Directed requests: {area_len, opt_byte, last}
  localparam logic [14:0] DIRECTED_REQS [23] = '{
    // NOP, copied option, short length, long length clamped to the area
    {6'd8, 8'h01, 1'b0}, {6'd8, 8'h83, 1'b0}, {6'd8, 8'h03, 1'b0}, {6'd8, 8'hff, 1'b0},
    {6'd8, 8'h07, 1'b0}, {6'd8, 8'h00, 1'b0}, {6'd8, 8'h89, 1'b0}, {6'd8, 8'hff, 1'b1},
    // uncopied option with length 1, then area ends on a copied type byte
    {6'd3, 8'h44, 1'b0}, {6'd3, 8'h01, 1'b0}, {6'd3, 8'h82, 1'b1},
    // zero-length area
    {6'd0, 8'haa, 1'b0}, {6'd0, 8'h55, 1'b1},
    // EOL first, area length beyond the maximum
    {6'd63, 8'h00, 1'b0}, {6'd63, 8'hff, 1'b1},
    // bytes past the area before last
    {6'd2, 8'h01, 1'b0}, {6'd2, 8'h01, 1'b0}, {6'd2, 8'hfe, 1'b0}, {6'd2, 8'h80, 1'b1},
    // kept count already a multiple of four
    {6'd4, 8'h86, 1'b0}, {6'd4, 8'h04, 1'b0}, {6'd4, 8'h00, 1'b0}, {6'd4, 8'hff, 1'b1}
  };

  logic clk;
  logic rst;
  logic no_idle;
  int   fail_count;
  int   pending;
  int   sent;
  int   idle_cycles;

  ifof_in_if  in_ch();
  ifof_out_if res_out();

  ipv4_fragment_option_filter_core #(
    .MAX_OPTION_BYTES(MAX_BYTES)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .res_out(res_out)
  );

  ifof_kept_byte_checker #(
    .MAX_OPTION_BYTES(MAX_BYTES)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .res_out   (res_out),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side stalls at random except in the quiet stretch
  always @(posedge clk) begin
    res_out.ready <= no_idle || ($urandom_range(99) >= 34);
  end

  // Watchdog on cycles with no request or result accepted
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (res_out.valid && res_out.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One request, with random gaps ahead of it; returns once accepted
  task automatic send_request(input logic [BYTE_W-1:0] opt_byte,
                              input logic [CNT_W-1:0] area_len, input logic last);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opt_byte <= opt_byte;
    in_ch.area_len <= area_len;
    in_ch.last     <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Hold off requests until every result due has come
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Build one option area of nbytes bytes and send it, last on the final byte
  task automatic send_area(input int area_len, input int nbytes, input bit noisy);
    logic [BYTE_W-1:0] area_q[$];
    int                room;
    int                pick;
    int                len;
    int                data;
    while (area_q.size() < nbytes) begin
      room = nbytes - area_q.size();
      pick = $urandom_range(99);
      if (noisy) begin
        area_q.push_back(BYTE_W'($urandom_range(255)));
      end else if (pick < 15) begin
        area_q.push_back(OPT_NOP);
      end else if (pick < 20) begin
        // EOL, then trailing garbage
        area_q.push_back(OPT_EOL);
        while (area_q.size() < nbytes) area_q.push_back(BYTE_W'($urandom_range(255)));
      end else begin
        area_q.push_back(BYTE_W'($urandom_range(2, 255)));
        if (room > 1) begin
          pick = $urandom_range(99);
          if (pick < 8)
            len = $urandom_range(0, 1);
          else if (pick < 16)
            len = $urandom_range(room + 1, 255);
          else
            len = $urandom_range(2, (room < 10) ? room : 10);
          area_q.push_back(BYTE_W'(len));
          data = (len < 2) ? 0 : len - 2;
          if (data > room - 2) data = room - 2;
          repeat (data) area_q.push_back(BYTE_W'($urandom_range(255)));
        end
      end
    end
    for (int i = 0; i < area_q.size(); i++)
      send_request(area_q[i], noisy ? CNT_W'($urandom_range(63)) : CNT_W'(area_len),
                   i == area_q.size() - 1);
  endtask

  initial begin
    int area_no;
    int kind;
    int area_len;
    int nbytes;
    rst            = 1'b1;
    no_idle        = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opt_byte = '0;
    in_ch.area_len = '0;
    in_ch.last     = 1'b0;
    res_out.ready  = 1'b0;
    area_no        = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < $size(DIRECTED_REQS); k++)
      send_request(DIRECTED_REQS[k][8:1], DIRECTED_REQS[k][14:9], DIRECTED_REQS[k][0]);
    wait_drained();

    // Random areas, mostly well formed
    sent = 0;
    while (sent < RANDOM_REQS) begin
      area_no++;
      no_idle <= (area_no >= 10 && area_no < 18);
      kind = $urandom_range(99);
      if (kind < 65) begin
        area_len = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 12);
        send_area(area_len, area_len, 1'b0);
      end else if (kind < 72) begin
        area_len = $urandom_range(41, 63);
        send_area(area_len, $urandom_range(41, area_len), 1'b0);
      end else if (kind < 80) begin
        area_len = $urandom_range(1, 40);
        send_area(area_len, area_len + $urandom_range(1, 4), 1'b0);
      end else if (kind < 87) begin
        area_len = $urandom_range(2, 40);
        send_area(area_len, $urandom_range(1, area_len - 1), 1'b0);
      end else if (kind < 92) begin
        send_area(0, $urandom_range(1, 3), 1'b0);
      end else begin
        nbytes = $urandom_range(1, 12);
        send_area(0, nbytes, 1'b1);
      end
      if (area_no == 20) wait_drained();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
